### hw/rtl/tsd_pkg.sv
// Shared types and constants of the temperature scratchpad decoder.
package tsd_pkg;

    localparam int SCRATCHPAD_BYTES_DEF = 9;

    // configuration byte position inside the scratchpad
    localparam int CONF_INDEX = 4;

    // CRC-8, x^8+x^5+x^4+1, LSB first
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    // resolution field, bits 6..5 of the configuration byte
    localparam int RES_HI = 6;
    localparam int RES_LO = 5;
    typedef logic [1:0] t_res;
    localparam t_res RES_9  = 2'b00;
    localparam t_res RES_10 = 2'b01;
    localparam t_res RES_11 = 2'b10;

    typedef logic [1:0] t_status;
    localparam t_status ST_VALID = 2'd0;
    localparam t_status ST_CRC   = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_LOW_LIMIT  = 2'd0;
    localparam t_cfg_index CFG_HIGH_LIMIT = 2'd1;

    localparam logic signed [15:0] LOW_LIMIT_RESET  = -16'sd550;
    localparam logic signed [15:0] HIGH_LIMIT_RESET = 16'sd1250;

    // completed frame handed from the frame tracker to the converter
    typedef struct packed {
        logic        valid;
        logic [15:0] raw;
        t_res        res;
        logic        crc_ok;
    } t_frame;

endpackage

### hw/rtl/tsd_frame.sv
// Frame tracker: byte count, running CRC-8 and capture of temperature and resolution.
module tsd_frame #(
    parameter int SCRATCHPAD_BYTES = tsd_pkg::SCRATCHPAD_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_frame_start,
    input  logic           i_frame_take,
    output tsd_pkg::t_frame o_frame
);

    localparam int CntW = $clog2(SCRATCHPAD_BYTES);
    localparam logic [CntW-1:0] LastIdx = CntW'(SCRATCHPAD_BYTES - 1);
    localparam logic [CntW-1:0] ConfIdx = CntW'(tsd_pkg::CONF_INDEX);

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++) begin
            mix = c[0] ^ d[0];
            c = c >> 1;
            if (mix) begin
                c = c ^ tsd_pkg::CRC_POLY_REFL;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    logic [7:0]      r_crc;
    logic [CntW-1:0] r_count;
    logic [7:0]      r_temp_low;
    logic [7:0]      r_temp_high;
    tsd_pkg::t_res   r_res;
    tsd_pkg::t_frame r_frame;

    logic [7:0]      crc_base;
    logic [CntW-1:0] cnt_base;
    logic [7:0]      n_crc;
    logic            accept;
    logic            last;
    tsd_pkg::t_res   byte_res;

    assign o_ready  = !r_frame.valid || i_frame_take;
    assign accept   = i_valid && o_ready;
    // a start mark restarts count and CRC before the byte is taken
    assign crc_base = i_frame_start ? 8'h00 : r_crc;
    assign cnt_base = i_frame_start ? '0 : r_count;
    assign n_crc    = crc_update(crc_base, i_data_byte);
    assign last     = (cnt_base == LastIdx);
    assign byte_res = i_data_byte[tsd_pkg::RES_HI:tsd_pkg::RES_LO];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc         <= 8'h00;
            r_count       <= '0;
            r_frame.valid <= 1'b0;
        end else if (accept) begin
            if (last) begin
                r_crc          <= 8'h00;
                r_count        <= '0;
                r_frame.valid  <= 1'b1;
                r_frame.raw    <= {r_temp_high, r_temp_low};
                // with a five byte scratchpad the last byte is the config byte
                r_frame.res    <= (cnt_base == ConfIdx) ? byte_res : r_res;
                r_frame.crc_ok <= (n_crc == 8'h00);
            end else begin
                r_crc   <= n_crc;
                r_count <= cnt_base + 1'b1;
                if (i_frame_take) begin
                    r_frame.valid <= 1'b0;
                end
            end
        end else if (i_frame_take) begin
            r_frame.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (cnt_base == '0) begin
                r_temp_low <= i_data_byte;
            end else if (cnt_base == CntW'(1)) begin
                r_temp_high <= i_data_byte;
            end else if (cnt_base == ConfIdx) begin
                r_res <= byte_res;
            end
        end
    end

    assign o_frame = r_frame;

endmodule

### hw/rtl/tsd_convert.sv
// Conversion to tenths of a degree, limit check and result register.
module tsd_convert (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tsd_pkg::t_frame        i_frame,
    output logic                   o_frame_take,
    input  logic signed [15:0]     i_low_limit,
    input  logic signed [15:0]     i_high_limit,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [15:0]     o_temperature,
    output tsd_pkg::t_status       o_status
);

    logic                    r_valid;
    logic signed [15:0]      r_temperature;
    tsd_pkg::t_status        r_status;

    logic                    neg;
    logic [15:0]             mag_raw;
    logic [15:0]             m;
    logic [11:0]             int_part;
    logic [14:0]             int_x10;
    logic [6:0]              frac5;
    logic [3:0]              frac;
    logic [14:0]             mag;
    logic signed [15:0]      t;
    tsd_pkg::t_status        n_status;
    logic signed [15:0]      n_temperature;

    assign o_frame_take = i_frame.valid && (!r_valid || i_ready);

    always_comb begin
        neg     = i_frame.raw[15];
        mag_raw = neg ? (~i_frame.raw + 16'd1) : i_frame.raw;
        case (i_frame.res)
            tsd_pkg::RES_9:  m = mag_raw & 16'hFFF8;
            tsd_pkg::RES_10: m = mag_raw & 16'hFFFC;
            tsd_pkg::RES_11: m = mag_raw & 16'hFFFE;
            default:         m = mag_raw;
        endcase
        int_part = m[15:4];
        int_x10  = {int_part, 3'b000} + {2'b00, int_part, 1'b0};
        // frac*640/1024 == frac*5/8; positive values add half an LSB first
        frac5 = {1'b0, m[3:0], 2'b00} + {3'b000, m[3:0]} + (neg ? 7'd0 : 7'd4);
        frac  = frac5[6:3];
        mag   = int_x10 + {11'd0, frac};
        t     = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        if (!i_frame.crc_ok) begin
            n_status      = tsd_pkg::ST_CRC;
            n_temperature = 16'sd0;
        end else if (t < i_low_limit || t > i_high_limit) begin
            n_status      = tsd_pkg::ST_RANGE;
            n_temperature = 16'sd0;
        end else begin
            n_status      = tsd_pkg::ST_VALID;
            n_temperature = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_frame_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frame_take) begin
            r_temperature <= n_temperature;
            r_status      <= n_status;
        end
    end

    assign o_valid       = r_valid;
    assign o_temperature = r_temperature;
    assign o_status      = r_status;

endmodule

### hw/rtl/temp_scratchpad_decoder.sv
// Top level of the temperature scratchpad decoder.
//
// Scratchpad bytes enter one per transaction, one per clock at full rate; a byte with
// i_frame_start high restarts the frame, otherwise frames follow each other back to
// back. The last byte of a frame produces one result once accepted: it passes through the
// frame tracker's hand-off register first and then through the converter's result
// register. Both registers advance together, so the input sustains one transaction per
// cycle while i_ready stays high; o_ready drops only when both hold a result that the
// output side has not taken. Status 1 is a CRC mismatch, 2 a value
// outside [low_limit, high_limit]; the temperature field is zero unless status is 0.
// Limits must be written through the configuration port while the block is idle; it does not enforce this.
module temp_scratchpad_decoder #(
    parameter int SCRATCHPAD_BYTES = tsd_pkg::SCRATCHPAD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_frame_start,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [15:0]          o_temperature,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tsd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);

    logic signed [15:0] r_low_limit;
    logic signed [15:0] r_high_limit;
    tsd_pkg::t_frame    frame;
    logic               frame_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= tsd_pkg::LOW_LIMIT_RESET;
            r_high_limit <= tsd_pkg::HIGH_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tsd_pkg::CFG_LOW_LIMIT:  r_low_limit  <= $signed(i_cfg_data);
                tsd_pkg::CFG_HIGH_LIMIT: r_high_limit <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    tsd_frame #(
        .SCRATCHPAD_BYTES(SCRATCHPAD_BYTES)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_frame_start(i_frame_start),
        .i_frame_take (frame_take),
        .o_frame      (frame)
    );

    tsd_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (frame),
        .o_frame_take (frame_take),
        .i_low_limit  (r_low_limit),
        .i_high_limit (r_high_limit),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_temperature(o_temperature),
        .o_status     (o_status)
    );

    // an invalid result never carries a temperature
    a_zero_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != tsd_pkg::ST_VALID) |-> o_temperature == 16'sd0)
        else $error("nonzero temperature on invalid result");

    // a valid result lies within the limits in force
    a_valid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == tsd_pkg::ST_VALID) |->
            (o_temperature >= r_low_limit) && (o_temperature <= r_high_limit))
        else $error("valid result outside limits");

    // a result only appears after a completed frame sat in the hand-off register
    a_result_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(frame.valid))
        else $error("result without a completed frame");

endmodule

### tb/temp_scratchpad_decoder_tb.sv
// Self-checking testbench for the temperature scratchpad decoder.
`timescale 1ns / 100ps

typedef struct {
    logic signed [15:0] temp;
    tsd_pkg::t_status   status;
} t_reading;

// CRC-8, LSB first, one byte
function automatic logic [7:0] crc8_next(logic [7:0] c, logic [7:0] d);
    logic mix;
    for (int i = 0; i < 8; i++) begin
        mix = c[0] ^ d[0];
        c = c >> 1;
        if (mix) begin
            c = c ^ tsd_pkg::CRC_POLY_REFL;
        end
        d = d >> 1;
    end
    return c;
endfunction

// Tracks scratchpad frames as the block sees them and queues the readings it must produce.
class scratchpad_tracker;
    t_reading           readings[$];
    logic signed [15:0] low_lim;
    logic signed [15:0] high_lim;
    logic [7:0]         crc;
    logic [7:0]         t_lo;
    logic [7:0]         t_hi;
    logic [7:0]         cfg_byte;
    int                 next_pos;
    int                 errors;

    function new();
        low_lim  = tsd_pkg::LOW_LIMIT_RESET;
        high_lim = tsd_pkg::HIGH_LIMIT_RESET;
        crc      = '0;
        t_lo     = '0;
        t_hi     = '0;
        cfg_byte = '0;
        next_pos = 0;
        errors   = 0;
    endfunction

    function void set_register(tsd_pkg::t_cfg_index idx, logic [15:0] data);
        case (idx)
            tsd_pkg::CFG_LOW_LIMIT: begin
                low_lim = data;
            end
            tsd_pkg::CFG_HIGH_LIMIT: begin
                high_lim = data;
            end
            default: begin
            end
        endcase
    endfunction

    // raw reading -> tenths; positive rounds, negative truncates
    function int to_tenths();
        logic [15:0] m;
        logic        neg;
        int          mag;
        m = {t_hi, t_lo};
        neg = m[15];
        if (neg) begin
            m = ~m + 16'd1;
        end
        case (cfg_byte[tsd_pkg::RES_HI:tsd_pkg::RES_LO])
            tsd_pkg::RES_9: begin
                m[2:0] = '0;
            end
            tsd_pkg::RES_10: begin
                m[1:0] = '0;
            end
            tsd_pkg::RES_11: begin
                m[0] = 1'b0;
            end
            default: begin
            end
        endcase
        mag = m[15:4] * 10 + (m[3:0] * 640 + (neg ? 0 : 512)) / 1024;
        return neg ? -mag : mag;
    endfunction

    function void take_byte(logic [7:0] b, logic start);
        int       t;
        t_reading r;
        if (start) begin
            next_pos = 0;
            crc = '0;
        end
        crc = crc8_next(crc, b);
        if (next_pos == 0) begin
            t_lo = b;
        end else if (next_pos == 1) begin
            t_hi = b;
        end else if (next_pos == tsd_pkg::CONF_INDEX) begin
            cfg_byte = b;
        end
        if (next_pos + 1 < tsd_pkg::SCRATCHPAD_BYTES_DEF) begin
            next_pos++;
            return;
        end
        next_pos = 0;
        if (crc != 8'd0) begin
            r.temp = '0;
            r.status = tsd_pkg::ST_CRC;
        end else begin
            t = to_tenths();
            if (t < int'(low_lim) || t > int'(high_lim)) begin
                r.temp = '0;
                r.status = tsd_pkg::ST_RANGE;
            end else begin
                r.temp = 16'(t);
                r.status = tsd_pkg::ST_VALID;
            end
        end
        crc = '0;
        readings.push_back(r);
    endfunction

    function void check_reading(logic signed [15:0] temp, tsd_pkg::t_status status);
        t_reading r;
        if (readings.size() == 0) begin
            $display("%0t: unexpected result, temperature %0d status %0d", $time, temp, status);
            errors++;
            return;
        end
        r = readings.pop_front();
        if (status !== r.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time, r.status, status);
            errors++;
        end
        if (temp !== r.temp) begin
            $display("%0t: temperature mismatch, expected %0d actual %0d",
                     $time, r.temp, temp);
            errors++;
        end
    endfunction
endclass

module temp_scratchpad_decoder_tb;

    localparam int FRAME_LEN = tsd_pkg::SCRATCHPAD_BYTES_DEF;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [7:0]          i_data_byte = '0;
    logic                i_frame_start = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [15:0]  o_temperature;
    logic [1:0]          o_status;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    tsd_pkg::t_cfg_index i_cfg_index = tsd_pkg::CFG_LOW_LIMIT;
    logic [15:0]         i_cfg_data = '0;

    scratchpad_tracker trk = new();

    logic [7:0] frm [FRAME_LEN];
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         bytes_sent = 0;
    logic       aligned = 1'b1;

    temp_scratchpad_decoder #(
        .SCRATCHPAD_BYTES(FRAME_LEN)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data_byte(i_data_byte),
        .i_frame_start(i_frame_start),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_temperature(o_temperature),
        .o_status(o_status),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // pre-edge values: output checked before the same-edge input is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                trk.check_reading(o_temperature, o_status);
            end
            if (i_valid && o_ready) begin
                trk.take_byte(i_data_byte, i_frame_start);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                trk.set_register(i_cfg_index, i_cfg_data);
            end
        end
    end

    task send_byte(input logic [7:0] b, input logic s);
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_frame_start <= s;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // fills frm with a well-formed scratchpad: CRC byte last
    function void build_frame(logic [15:0] raw, logic [7:0] cfg);
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            if (i == 0) begin
                frm[i] = raw[7:0];
            end else if (i == 1) begin
                frm[i] = raw[15:8];
            end else if (i == tsd_pkg::CONF_INDEX) begin
                frm[i] = cfg;
            end else begin
                frm[i] = 8'($urandom);
            end
            c = crc8_next(c, frm[i]);
        end
        frm[FRAME_LEN-1] = c;
    endfunction

    task send_frame(input logic mark);
        for (int i = 0; i < FRAME_LEN; i++) begin
            send_byte(frm[i], (i == 0) ? mark : 1'b0);
        end
    endtask

    task settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (trk.readings.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // one write to an unused index, then both limits, valid held across all three
    task write_limits(input logic [15:0] lo, input logic [15:0] hi);
        tsd_pkg::t_cfg_index idx [3];
        logic [15:0]         val [3];
        idx[0] = tsd_pkg::t_cfg_index'(tsd_pkg::CFG_HIGH_LIMIT + 1 + $urandom_range(1));
        val[0] = 16'($urandom);
        idx[1] = tsd_pkg::CFG_LOW_LIMIT;
        val[1] = lo;
        idx[2] = tsd_pkg::CFG_HIGH_LIMIT;
        val[2] = hi;
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task pick_limits(input int sel);
        int lo;
        case (sel)
            0: write_limits(-16'sd20480, 16'sd20480);
            1: write_limits(tsd_pkg::LOW_LIMIT_RESET, tsd_pkg::HIGH_LIMIT_RESET);
            2: begin
                lo = int'($urandom_range(800)) - 600;
                write_limits(16'(lo), 16'(lo + int'($urandom_range(1500))));
            end
            3: write_limits(16'($urandom), 16'($urandom));
            default: begin
                if ($urandom_range(1) == 1) begin
                    write_limits(16'sd20480, 16'sd20480);
                end else begin
                    write_limits(-16'sd20480, -16'sd20480);
                end
            end
        endcase
    endtask

    task random_chunk();
        int          k;
        int          n;
        logic [15:0] raw;
        k = $urandom_range(99);
        if ($urandom_range(1) == 1) begin
            raw = 16'(int'($urandom_range(2880)) - 880);
        end else begin
            raw = 16'($urandom);
        end
        if (k < 85) begin
            build_frame(raw, 8'($urandom));
            if (k >= 75) begin
                n = $urandom_range(FRAME_LEN - 1);
                frm[n] = frm[n] ^ 8'(1 << $urandom_range(7));
            end
            send_frame(!aligned || ($urandom_range(1) == 1));
            aligned = 1'b1;
        end else if (k < 95) begin
            n = $urandom_range(1, 12);
            repeat (n) send_byte(8'($urandom), $urandom_range(9) == 0);
            aligned = 1'b0;
        end else begin
            // frame abandoned part way; the next one restarts with a start mark
            n = $urandom_range(1, FRAME_LEN - 1);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom), i == 0);
            end
            aligned = 1'b0;
        end
    endtask

    initial begin
        int start_cnt;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limits -550..1250
        build_frame(16'h0191, 8'h7F);
        send_frame(1'b1);
        build_frame(16'hFF5E, 8'h7F);   // back to back, no start mark
        send_frame(1'b0);
        build_frame(16'h0550, 8'h1F);
        frm[FRAME_LEN-1] = frm[FRAME_LEN-1] ^ 8'h01;
        send_frame(1'b0);
        build_frame(16'h07D1, 8'h7F);   // one step above the high limit
        send_frame(1'b0);
        for (int i = 0; i < 3; i++) begin
            send_byte(8'($urandom), i == 0);
        end
        build_frame(16'hFC90, 8'h7F);   // restart mid-frame, low limit exactly
        send_frame(1'b1);

        settle();
        write_limits(-16'sd20480, 16'sd20480);
        build_frame(16'h8000, 8'h7F);
        send_frame(1'b1);
        build_frame(16'h7FFF, 8'h7F);
        send_frame(1'b0);
        build_frame(16'h0197, 8'h1F);
        send_frame(1'b0);
        build_frame(16'h0197, 8'h3F);
        send_frame(1'b0);
        build_frame(16'h0197, 8'h5F);
        send_frame(1'b0);
        build_frame(16'hFFFF, 8'h5F);
        send_frame(1'b0);

        settle();
        write_limits(16'sd100, -16'sd100);  // limits crossed
        build_frame(16'h0000, 8'h7F);
        send_frame(1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            for (int blk = 0; blk < 2; blk++) begin
                settle();
                pick_limits((ph == 0 && blk == 0) ? 0 : $urandom_range(4));
                start_cnt = bytes_sent;
                while (bytes_sent - start_cnt < 60) begin
                    random_chunk();
                end
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (trk.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_frame.sv
hw/rtl/tsd_convert.sv
hw/rtl/temp_scratchpad_decoder.sv
tb/temp_scratchpad_decoder_tb.sv
